>>> hdl/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared constants, types and helpers of the route prefix lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PORT_COUNT  = 4;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 2;
  localparam int EIDX_W  = 4;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } rpl_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } rpl_entry_t;

  typedef struct packed {
    logic              hit;
    logic              better;
    logic [ADDR_W-1:0] len_mask;
  } rpl_match_t;

  // Clamp an interface number to the last port.
  function automatic logic [PORT_W-1:0] clamp_port(input logic [PORT_W-1:0] p);
    logic [PORT_W-1:0] r;
    if (32'(p) >= PORT_COUNT) begin
      r = PORT_W'(PORT_COUNT - 1);
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rpl_in_if.sv
// ----------------------------------------------------------------------------
// rpl_in_if
// Request channel: write or lookup words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpl_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  entry_index;
  logic        entry_valid;
  logic [31:0] route_prefix;
  logic [31:0] route_netmask;
  logic [31:0] route_next_hop;
  logic [1:0]  route_out_port;
  logic [31:0] lookup_address;

  modport source (
    output valid, opcode, entry_index, entry_valid, route_prefix,
           route_netmask, route_next_hop, route_out_port, lookup_address,
    input  ready
  );

  modport sink (
    input  valid, opcode, entry_index, entry_valid, route_prefix,
           route_netmask, route_next_hop, route_out_port, lookup_address,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/rpl_out_if.sv
// ----------------------------------------------------------------------------
// rpl_out_if
// Result channel: one word per request with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [3:0]  matched_entry;
  logic [31:0] next_hop;
  logic [1:0]  out_port;
  logic        via_gateway;
  logic        write_done;

  modport source (
    output valid, found, matched_entry, next_hop, out_port, via_gateway,
           write_done,
    input  ready
  );

  modport sink (
    input  valid, found, matched_entry, next_hop, out_port, via_gateway,
           write_done,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/rpl_table.sv
// ----------------------------------------------------------------------------
// rpl_table
// Route entry memory with one write port, one registered read port and
// per-entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_table (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [rpl_pkg::IDX_W-1:0] wr_addr,
  input  wire rpl_pkg::rpl_entry_t      wr_entry,
  input  wire logic                     wr_valid,
  input  wire logic [rpl_pkg::IDX_W-1:0] rd_addr,
  output      rpl_pkg::rpl_entry_t      rd_entry,
  output      logic                     rd_valid
);
  import rpl_pkg::*;

  rpl_entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_bits[wr_addr] <= wr_valid;
      end
      rd_valid <= valid_bits[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/rpl_match.sv
// ----------------------------------------------------------------------------
// rpl_match
// Shared prefix comparator: checks one entry against the address and
// against the best prefix so far.
// ----------------------------------------------------------------------------
`default_nettype none

module rpl_match (
  input  wire logic [rpl_pkg::ADDR_W-1:0] addr,
  input  wire logic [rpl_pkg::ADDR_W-1:0] dest,
  input  wire logic [rpl_pkg::ADDR_W-1:0] mask,
  input  wire logic                       have_best,
  input  wire logic [rpl_pkg::ADDR_W-1:0] best_len_mask,
  output      rpl_pkg::rpl_match_t        result
);
  import rpl_pkg::*;

  logic [ADDR_W-1:0] len_mask;

  // Keep only the leading run of ones; the result is a thermometer code,
  // so a longer prefix compares as a larger number.
  always_comb begin
    len_mask[ADDR_W-1] = mask[ADDR_W-1];
    for (int i = ADDR_W - 2; i >= 0; i--) begin
      len_mask[i] = len_mask[i+1] & mask[i];
    end
  end

  assign result.len_mask = len_mask;
  assign result.hit      = (((dest ^ addr) & len_mask) == '0);
  assign result.better   = !have_best || (len_mask > best_len_mask);

endmodule

`default_nettype wire

>>> hdl/route_prefix_lookup.sv
// ----------------------------------------------------------------------------
// route_prefix_lookup
// IPv4 longest-prefix-match routing table with a sequential scan.
// ----------------------------------------------------------------------------
// The table holds TABLE_DEPTH routes (destination, netmask, gateway, output
// port, valid). A write word (opcode 0) stores one entry, clamps the port to
// the last interface and is acknowledged with write_done; a write to an index
// past the table is dropped but still acknowledged. A lookup word (opcode 1)
// scans every entry through one shared prefix comparator, one entry per
// cycle, fed by the single read port of the table memory. The valid matching
// entry with the longest run of leading netmask ones wins, ties to the lowest
// index; with no match, a valid entry 0 serves as default route, otherwise
// found is 0 and the route fields are 0. via_gateway flags a chosen entry
// whose destination is zero. A lookup passes through the scan, a drain state
// for the registered read of the last entry and a done state that loads the
// result into the output register; a write goes straight to the done state.
// The request side is ready again in the cycle after the result is loaded,
// while the result may still wait in the output register for the sink; a
// result that cannot load because the register is still full stalls the
// block until the sink takes the older word.
// ----------------------------------------------------------------------------
`default_nettype none

module route_prefix_lookup (
  input  wire logic clk,
  input  wire logic rst,
  rpl_in_if.sink    in_ch,
  rpl_out_if.source out_ch
);
  import rpl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  cnt;
  logic [ADDR_W-1:0] addr;
  logic              is_wr;

  // Evaluation stage: tracks the entry whose read data arrives this cycle.
  logic              ev_v;
  logic [IDX_W-1:0]  ev_idx;

  // Best route so far.
  logic              have;
  logic              v0;
  logic [ADDR_W-1:0] best_lm;
  logic [IDX_W-1:0]  best_idx;
  logic [ADDR_W-1:0] best_gw;
  logic [PORT_W-1:0] best_port;
  logic              best_dz;

  // Output register.
  logic              out_valid;
  logic              found_r;
  logic [EIDX_W-1:0] matched_r;
  logic [ADDR_W-1:0] next_hop_r;
  logic [PORT_W-1:0] out_port_r;
  logic              via_gw_r;
  logic              write_done_r;

  logic              in_acc;
  logic              wr_en;
  rpl_entry_t        wr_entry;
  rpl_entry_t        rd_entry;
  logic              rd_valid;
  rpl_match_t        m;
  logic              out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // Write straight into the table on acceptance; drop out-of-range slots.
  assign wr_en = in_acc && (rpl_op_t'(in_ch.opcode) == OP_WRITE)
                 && (32'(in_ch.entry_index) < TABLE_DEPTH);

  assign wr_entry.dest    = in_ch.route_prefix;
  assign wr_entry.mask    = in_ch.route_netmask;
  assign wr_entry.gateway = in_ch.route_next_hop;
  assign wr_entry.port    = clamp_port(in_ch.route_out_port);

  rpl_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (IDX_W'(in_ch.entry_index)),
    .wr_entry (wr_entry),
    .wr_valid (in_ch.entry_valid),
    .rd_addr  (cnt),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  rpl_match u_match (
    .addr          (addr),
    .dest          (rd_entry.dest),
    .mask          (rd_entry.mask),
    .have_best     (have),
    .best_len_mask (best_lm),
    .result        (m)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.found         = found_r;
  assign out_ch.matched_entry = matched_r;
  assign out_ch.next_hop      = next_hop_r;
  assign out_ch.out_port      = out_port_r;
  assign out_ch.via_gateway   = via_gw_r;
  assign out_ch.write_done    = write_done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ev_v      <= 1'b0;
      cnt       <= '0;
    end else begin
      ev_v   <= (state == S_SCAN);
      ev_idx <= cnt;

      // Drop the taken word unless the next result loads in the same cycle.
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      // Entry 0 always seeds the best registers so that it is on hand as
      // the default route; later entries replace it only on a real match.
      if (ev_v) begin
        if (ev_idx == '0) begin
          have      <= rd_valid && m.hit;
          v0        <= rd_valid;
          best_lm   <= m.len_mask;
          best_idx  <= '0;
          best_gw   <= rd_entry.gateway;
          best_port <= rd_entry.port;
          best_dz   <= (rd_entry.dest == '0);
        end else if (rd_valid && m.hit && m.better) begin
          have      <= 1'b1;
          best_lm   <= m.len_mask;
          best_idx  <= ev_idx;
          best_gw   <= rd_entry.gateway;
          best_port <= rd_entry.port;
          best_dz   <= (rd_entry.dest == '0);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (rpl_op_t'(in_ch.opcode) == OP_WRITE) begin
              is_wr <= 1'b1;
              state <= S_DONE;
            end else begin
              is_wr <= 1'b0;
              addr  <= in_ch.lookup_address;
              cnt   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Advance the read address; the last read is compared in S_DRAIN, once
          // its registered data has arrived.
          if (cnt == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (is_wr) begin
              found_r      <= 1'b0;
              matched_r    <= '0;
              next_hop_r   <= '0;
              out_port_r   <= '0;
              via_gw_r     <= 1'b0;
              write_done_r <= 1'b1;
            end else if (have || v0) begin
              found_r      <= 1'b1;
              matched_r    <= EIDX_W'(best_idx);
              next_hop_r   <= best_gw;
              out_port_r   <= best_port;
              via_gw_r     <= best_dz;
              write_done_r <= 1'b0;
            end else begin
              found_r      <= 1'b0;
              matched_r    <= '0;
              next_hop_r   <= '0;
              out_port_r   <= '0;
              via_gw_r     <= 1'b0;
              write_done_r <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_route_prefix_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_route_prefix_lookup
// Self-checking bench for the route prefix lookup block. A shadow routing
// table predicts every answer word. A directed pass covers default routes,
// host routes, ties, non-contiguous masks and invalidation. Random traffic,
// mostly lookups aimed at programmed prefixes, then runs under several
// handshake idling patterns and one long output back-pressure stretch.
// ----------------------------------------------------------------------------

module tb_route_prefix_lookup;
  import rpl_pkg::*;

  // One request word as the bench sees it.
  typedef struct {
    rpl_op_t           opcode;
    logic [EIDX_W-1:0] entry_index;
    logic              entry_valid;
    logic [ADDR_W-1:0] route_prefix;
    logic [ADDR_W-1:0] route_netmask;
    logic [ADDR_W-1:0] route_next_hop;
    logic [PORT_W-1:0] route_out_port;
    logic [ADDR_W-1:0] lookup_address;
  } route_word_t;

  // One answer word, as predicted from the shadow table.
  typedef struct {
    logic              found;
    logic [EIDX_W-1:0] matched_entry;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] out_port;
    logic              via_gateway;
    logic              write_done;
  } route_answer_t;

  logic clk = 1'b0;
  logic rst;

  rpl_in_if  in_ch ();
  rpl_out_if out_ch ();

  route_prefix_lookup dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the routing table; live bits mirror the valid bits.
  rpl_entry_t route_table [TABLE_DEPTH];
  logic       route_live  [TABLE_DEPTH];

  // Answers still owed by the block, oldest first.
  route_answer_t pending_routes[$];

  int  mismatch_count = 0;
  int  src_idle_pct   = 0;   // chance per cycle that the sender holds off
  int  sink_stall_pct = 0;   // chance per cycle that the receiver stalls
  bit  sink_hold      = 1'b0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up long after the slowest legal run would have ended.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: update the shadow table for writes, scan it for lookups.
  // --------------------------------------------------------------------------
  function automatic route_answer_t compute_route(route_word_t w);
    route_answer_t     a;
    logic [PORT_W-1:0] port;
    bit                hit;
    int                best;
    int                best_len;
    int                len;
    int                i;
    a.found         = 1'b0;
    a.matched_entry = '0;
    a.next_hop      = '0;
    a.out_port      = '0;
    a.via_gateway   = 1'b0;
    a.write_done    = 1'b0;
    if (w.opcode == OP_WRITE) begin
      // Drop writes past the table but still acknowledge them.
      if (int'(w.entry_index) < TABLE_DEPTH) begin
        port = w.route_out_port;
        if (int'(port) >= PORT_COUNT) begin
          port = PORT_W'(PORT_COUNT - 1);
        end
        route_table[w.entry_index].dest    = w.route_prefix;
        route_table[w.entry_index].mask    = w.route_netmask;
        route_table[w.entry_index].gateway = w.route_next_hop;
        route_table[w.entry_index].port    = port;
        route_live[w.entry_index]          = w.entry_valid;
      end
      a.write_done = 1'b1;
    end else begin
      hit      = 1'b0;
      best     = 0;
      best_len = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (route_live[i]) begin
          // Prefix length is the run of leading ones only.
          len = 0;
          while (len < ADDR_W && route_table[i].mask[ADDR_W-1-len]) begin
            len++;
          end
          if (len == 0 ||
              (route_table[i].dest >> (ADDR_W - len)) ==
              (w.lookup_address >> (ADDR_W - len))) begin
            // Strictly longer wins, so ties stay with the lowest index.
            if (!hit || len > best_len) begin
              hit      = 1'b1;
              best     = i;
              best_len = len;
            end
          end
        end
      end
      // Fall back to entry 0 as default route when it is live.
      if (!hit && route_live[0]) begin
        hit  = 1'b1;
        best = 0;
      end
      if (hit) begin
        a.found         = 1'b1;
        a.matched_entry = EIDX_W'(best);
        a.next_hop      = route_table[best].gateway;
        a.out_port      = route_table[best].port;
        a.via_gateway   = (route_table[best].dest == '0);
      end
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Random word: mostly lookups near programmed prefixes, some table churn.
  // --------------------------------------------------------------------------
  function automatic route_word_t make_route_word();
    route_word_t       w;
    logic [ADDR_W-1:0] mask;
    int                len;
    int                pick;
    int                j;
    // Fill every field so unused ones still toggle.
    w.entry_index    = EIDX_W'($urandom_range(TABLE_DEPTH - 1));
    w.entry_valid    = ($urandom_range(99) < 85);
    w.route_prefix   = $urandom;
    w.route_netmask  = $urandom;
    w.route_next_hop = $urandom;
    w.route_out_port = PORT_W'($urandom);
    w.lookup_address = $urandom;
    j                = $urandom_range(TABLE_DEPTH - 1);
    if ($urandom_range(99) < 30) begin
      w.opcode = OP_WRITE;
      len      = $urandom_range(ADDR_W);
      mask     = {ADDR_W{1'b1}} << (ADDR_W - len);
      pick     = $urandom_range(99);
      // Keep most masks contiguous; leave some fully random or holed.
      if (pick < 15) begin
        mask = w.route_netmask;
      end else if (pick < 30) begin
        mask = mask | (w.route_netmask & ~mask);
      end
      w.route_netmask = mask;
      pick = $urandom_range(99);
      if (pick < 10) begin
        w.route_prefix = '0;
      end else if (pick < 50) begin
        // Nest under or tie with an existing route.
        w.route_prefix = route_table[j].dest ^ (w.route_prefix & ~mask);
      end
    end else begin
      w.opcode = OP_LOOKUP;
      pick     = $urandom_range(99);
      if (pick < 65) begin
        // Aim near an entry: disturb only a random number of low bits.
        len = $urandom_range(ADDR_W);
        w.lookup_address = route_table[j].dest ^
                           (w.lookup_address & ({ADDR_W{1'b1}} >> (ADDR_W - len)));
      end else if (pick < 70) begin
        w.lookup_address = '0;
      end else if (pick < 75) begin
        w.lookup_address = {ADDR_W{1'b1}};
      end
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one word at a falling edge, hold it until accepted.
  // --------------------------------------------------------------------------
  task automatic send_word(route_word_t w);
    bit taken;
    @(negedge clk);
    // Idle the request channel for a random number of cycles.
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= w.opcode;
    in_ch.entry_index    <= w.entry_index;
    in_ch.entry_valid    <= w.entry_valid;
    in_ch.route_prefix   <= w.route_prefix;
    in_ch.route_netmask  <= w.route_netmask;
    in_ch.route_next_hop <= w.route_next_hop;
    in_ch.route_out_port <= w.route_out_port;
    in_ch.lookup_address <= w.lookup_address;
    // Wait for the edge where valid meets ready.
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (in_ch.ready === 1'b1);
    end
    pending_routes.push_back(compute_route(w));
  endtask

  task automatic send_write(input logic [EIDX_W-1:0] idx, input logic live,
                            input logic [ADDR_W-1:0] dest,
                            input logic [ADDR_W-1:0] mask,
                            input logic [ADDR_W-1:0] gw,
                            input logic [PORT_W-1:0] port);
    route_word_t w;
    w.opcode         = OP_WRITE;
    w.entry_index    = idx;
    w.entry_valid    = live;
    w.route_prefix   = dest;
    w.route_netmask  = mask;
    w.route_next_hop = gw;
    w.route_out_port = port;
    w.lookup_address = $urandom;
    send_word(w);
  endtask

  task automatic send_lookup(input logic [ADDR_W-1:0] addr);
    route_word_t w;
    w.opcode         = OP_LOOKUP;
    w.entry_index    = EIDX_W'($urandom);
    w.entry_valid    = 1'($urandom);
    w.route_prefix   = $urandom;
    w.route_netmask  = $urandom;
    w.route_next_hop = $urandom;
    w.route_out_port = PORT_W'($urandom);
    w.lookup_address = addr;
    send_word(w);
  endtask

  task automatic run_random_words(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      send_word(make_route_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: decide ready at each falling edge; a hold forces a stall.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || sink_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got %h, wanted %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Check each accepted answer word against the oldest prediction.
  always @(posedge clk) begin
    route_answer_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("unexpected answer word, found", 32'(out_ch.found), '0);
      end else begin
        want = pending_routes.pop_front();
        if (out_ch.found !== want.found)
          report_mismatch("found", 32'(out_ch.found), 32'(want.found));
        if (out_ch.matched_entry !== want.matched_entry)
          report_mismatch("matched_entry", 32'(out_ch.matched_entry),
                          32'(want.matched_entry));
        if (out_ch.next_hop !== want.next_hop)
          report_mismatch("next_hop", out_ch.next_hop, want.next_hop);
        if (out_ch.out_port !== want.out_port)
          report_mismatch("out_port", 32'(out_ch.out_port), 32'(want.out_port));
        if (out_ch.via_gateway !== want.via_gateway)
          report_mismatch("via_gateway", 32'(out_ch.via_gateway),
                          32'(want.via_gateway));
        if (out_ch.write_done !== want.write_done)
          report_mismatch("write_done", 32'(out_ch.write_done),
                          32'(want.write_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk through the corner cases of the match rules one by one.
  task automatic test_directed_routes();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // Empty table: nothing found, all route fields zero.
    send_lookup(32'h0A00_0001);
    // Catch-all default route in entry 0, zero destination.
    send_write(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 2'd3);
    send_lookup(32'hFFFF_FFFF);
    // Host route at the top slot, all fields at their maximum.
    send_write(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFE);
    // Nested /8 and /16: the longer prefix must win.
    send_write(4'd5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 2'd1);
    send_write(4'd3, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 2'd2);
    send_lookup(32'h0A01_0203);
    send_lookup(32'h0A7F_0000);
    // Equal-length tie: the lower index keeps the route.
    send_write(4'd9, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0909_0909, 2'd0);
    send_lookup(32'h0A01_FFFF);
    // Holed netmask: only the leading ones form the prefix.
    send_write(4'd2, 1'b1, 32'hC000_0000, 32'hF0F0_0000, 32'h0202_0202, 2'd0);
    send_lookup(32'hC5A5_A5A5);
    // Invalidate the tie winner: the other tied entry takes over.
    send_write(4'd3, 1'b0, 32'h1234_5678, 32'hFFFF_FF00, 32'h8765_4321, 2'd1);
    send_lookup(32'h0A01_0203);
    // Invalidate entry 0: a miss now finds nothing.
    send_write(4'd0, 1'b0, 32'hDEAD_BEEF, 32'h8000_0000, 32'h1111_1111, 2'd2);
    send_lookup(32'h1234_5678);
    // Live entry 0 that does not match still serves as default route.
    send_write(4'd0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 2'd0);
    send_lookup(32'h0000_0001);
    // /31 on a zero destination: a real match flagged as via gateway.
    send_write(4'd1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFE, 32'h5555_AAAA, 2'd1);
    send_lookup(32'h0000_0001);
    send_lookup(32'h0000_0000);
  endtask

  task automatic test_streaming();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random_words(370);
  endtask

  task automatic test_sender_gaps();
    src_idle_pct   = 68;
    sink_stall_pct = 0;
    run_random_words(370);
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct   = 0;
    sink_stall_pct = 68;
    run_random_words(370);
  endtask

  task automatic test_mixed_idling();
    src_idle_pct   = 16;
    sink_stall_pct = 16;
    run_random_words(370);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills its output register and stalls the request side.
  task automatic test_backpressure_fill();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (600) @(posedge clk);
        sink_hold = 1'b0;
      end
      run_random_words(50);
    join
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = 1'b0;
    in_ch.entry_index    = '0;
    in_ch.entry_valid    = 1'b0;
    in_ch.route_prefix   = '0;
    in_ch.route_netmask  = '0;
    in_ch.route_next_hop = '0;
    in_ch.route_out_port = '0;
    in_ch.lookup_address = '0;
    out_ch.ready         = 1'b0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      route_table[i] = '0;
      route_live[i]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_routes();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure_fill();

    // Drop valid, drain the owed answers, then watch for stray words.
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    sink_stall_pct = 0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (4 * TABLE_DEPTH) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rpl_pkg.sv
hdl/rpl_in_if.sv
hdl/rpl_out_if.sv
hdl/rpl_table.sv
hdl/rpl_match.sv
hdl/route_prefix_lookup.sv
bench/tb_route_prefix_lookup.sv
